@@ src/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the digit glyph lookup for the integer to
// ASCII digit converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Field widths fixed by the item format
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;

  // Radix limits and the radix that shows a sign
  localparam logic [RADIX_W-1:0] RADIX_MIN    = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_SIGNED = 5'd10;

  // Quotient bits retired per divide cycle
  localparam int DIV_STEPS = 8;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } itoa_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic div_step;
    logic emit_load;
  } itoa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_final;
    logic more_digits;
    logic emit_final;
    logic out_free;
  } itoa_sts_t;

  // Map a digit to its upper-case ASCII glyph
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] digit);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, digit};
    if (digit < DIGIT_TEN) begin
      digit_glyph = CHAR_ZERO + ext;
    end else begin
      digit_glyph = CHAR_A + ext - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
    end
  endfunction

endpackage

@@ src/itoa_in_if.sv @@
// ----------------------------------------------------------------------------
// itoa_in_if
// Input channel: value, radix and signed flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface itoa_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [4:0]             radix;
  logic                   signed_mode;

  modport source (output valid, output value, output radix, output signed_mode,
                  input ready);
  modport sink   (input valid, input value, input radix, input signed_mode,
                  output ready);
endinterface

@@ src/itoa_out_if.sv @@
// ----------------------------------------------------------------------------
// itoa_out_if
// Output channel: one ASCII character per beat with a last marker.
// ----------------------------------------------------------------------------
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ src/itoa_dp.sv @@
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: sign handling, multi-cycle radix divider, digit memory and the
// output character register.
// ----------------------------------------------------------------------------
module itoa_dp #(
  parameter int VALUE_WIDTH = 32,
  parameter int DIGIT_DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  itoa_pkg::itoa_cmd_t                 cmd_i,
  output itoa_pkg::itoa_sts_t                 sts_o,
  input  logic [VALUE_WIDTH-1:0]              value_i,
  input  logic [itoa_pkg::RADIX_W-1:0]        radix_i,
  input  logic                                signed_mode_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [itoa_pkg::CHAR_W-1:0]         character_o,
  output logic                                last_o
);
  import itoa_pkg::*;

  localparam int BitsW = $clog2(VALUE_WIDTH + 1);
  localparam int CntW  = $clog2(DIGIT_DEPTH + 1);
  localparam int IdxW  = $clog2(DIGIT_DEPTH);

  logic [VALUE_WIDTH-1:0] quot_q;
  logic [RADIX_W-1:0]     rem_q;
  logic [RADIX_W-1:0]     radix_q;
  logic [BitsW-1:0]       bits_left_q;
  logic [CntW-1:0]        count_q;
  logic                   sign_q;
  logic                   out_valid_q;
  logic [CHAR_W-1:0]      out_char_q;
  logic                   out_last_q;
  logic [DIGIT_W-1:0]     digit_mem [DIGIT_DEPTH];

  logic [RADIX_W-1:0]     radix_sat;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] quot_v;
  logic [RADIX_W-1:0]     rem_v;
  logic [CntW-1:0]        count_m1;
  logic [IdxW-1:0]        rd_idx;

  // Clamp the radix and detect a negative decimal value
  always_comb begin
    if (radix_i < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = radix_i;
    end
    negative = signed_mode_i && (radix_sat == RADIX_SIGNED) && value_i[VALUE_WIDTH-1];
  end

  // Restoring division, up to DIV_STEPS quotient bits per cycle
  always_comb begin
    quot_v = quot_q;
    rem_v  = rem_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (BitsW'(i) < bits_left_q) begin
        rem_v = {rem_v[RADIX_W-2:0], quot_v[VALUE_WIDTH-1]};
        if (rem_v >= radix_q) begin
          rem_v  = rem_v - radix_q;
          quot_v = {quot_v[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          quot_v = {quot_v[VALUE_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  assign count_m1 = count_q - CntW'(1);
  assign rd_idx   = count_m1[IdxW-1:0];

  // Status toward the controller
  always_comb begin
    sts_o.div_final   = (bits_left_q <= BitsW'(DIV_STEPS));
    sts_o.more_digits = (quot_v != '0) && (count_q < CntW'(DIGIT_DEPTH - 1));
    sts_o.emit_final  = !sign_q && (count_q == CntW'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Control registers: divide progress, digit count, sign, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_left_q <= '0;
      count_q     <= '0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        bits_left_q <= BitsW'(VALUE_WIDTH);
        count_q     <= '0;
        sign_q      <= negative;
      end else if (cmd_i.div_step) begin
        if (sts_o.div_final) begin
          bits_left_q <= BitsW'(VALUE_WIDTH);
          count_q     <= count_q + CntW'(1);
        end else begin
          bits_left_q <= bits_left_q - BitsW'(DIV_STEPS);
        end
      end else if (cmd_i.emit_load) begin
        if (sign_q) begin
          sign_q <= 1'b0;
        end else begin
          count_q <= count_m1;
        end
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and digit memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      radix_q <= radix_sat;
      quot_q  <= negative ? (~value_i + VALUE_WIDTH'(1)) : value_i;
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_v;
      if (sts_o.div_final) begin
        rem_q                           <= '0;
        digit_mem[count_q[IdxW-1:0]]    <= rem_v[DIGIT_W-1:0];
      end else begin
        rem_q <= rem_v;
      end
    end
    if (cmd_i.emit_load) begin
      if (sign_q) begin
        out_char_q <= CHAR_MINUS;
        out_last_q <= 1'b0;
      end else begin
        out_char_q <= digit_glyph(digit_mem[rd_idx]);
        out_last_q <= (count_q == CntW'(1));
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = out_char_q;
  assign last_o      = out_last_q;

endmodule

@@ src/itoa_ctrl.sv @@
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: sequences accept, divide and emit phases of one item.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  itoa_pkg::itoa_sts_t sts_i,
  output itoa_pkg::itoa_cmd_t cmd_o
);
  import itoa_pkg::*;

  itoa_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts_i.div_final && !sts_i.more_digits) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.emit_final) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.load_item = 1'b0;
    cmd_o.div_step  = 1'b0;
    cmd_o.emit_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit_load = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/integer_to_ascii_digits_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top
// Converts a value in radix 2 to 16 into its ASCII digits, most significant
// first, with a leading '-' for negative signed decimal values.
// ----------------------------------------------------------------------------
// One item is taken at a time. After a beat is accepted, each digit is worked out
// by the shared radix divider, then the characters leave at one per cycle when the
// sink is ready, the sign first. The next item is accepted while the last
// character still waits in the output register.
module integer_to_ascii_digits_top #(
  parameter int VALUE_WIDTH = 32,
  parameter int DIGIT_DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  itoa_in_if.sink    in_i,
  itoa_out_if.source out_o
);
  import itoa_pkg::*;

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (in_i.value),
    .radix_i       (in_i.radix),
    .signed_mode_i (in_i.signed_mode),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .character_o   (out_o.character),
    .last_o        (out_o.last)
  );

  // Once a beat is taken, the next one is not accepted back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted on consecutive cycles");

  // A sign never ends a number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.character == CHAR_MINUS)) |-> !out_o.last)
    else $error("minus sign marked last");

  // Every emitted character is a sign, a decimal digit or A-F
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.character == CHAR_MINUS) ||
                     ((out_o.character >= CHAR_ZERO) && (out_o.character <= 7'h39)) ||
                     ((out_o.character >= CHAR_A) && (out_o.character <= 7'h46))))
    else $error("character outside the digit set");

endmodule

@@ bench/integer_to_ascii_digits_checker.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_checker
// Watches both channels of the digit converter, expands every accepted
// number into the characters it must produce and compares each output beat,
// field by field, against the oldest character still owed.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_checker #(
  parameter int VALUE_WIDTH = 32,
  parameter int DIGIT_DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [VALUE_WIDTH-1:0]           in_value_i,
  input  logic [itoa_pkg::RADIX_W-1:0]     in_radix_i,
  input  logic                             in_signed_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [itoa_pkg::CHAR_W-1:0]      out_char_i,
  input  logic                             out_last_i,
  output int                               owed_chars_o,
  output int                               fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import itoa_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } char_beat_t;

  // Characters still owed by the block, oldest first
  char_beat_t owed_chars[$];

  // Private copy of the converter state
  logic [VALUE_WIDTH-1:0] quotient_r;
  logic [DIGIT_W-1:0]     digit_mem [DIGIT_DEPTH];
  int                     n_digits;
  logic                   minus_due;

  int         fails;
  char_beat_t want;

  function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [DIGIT_W-1:0] digit);
    if (digit < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(digit);
    end
    return CHAR_A + CHAR_W'(digit - DIGIT_TEN);
  endfunction

  // Divide the number down into digits, then queue them most significant first
  task automatic expand_number(input logic [VALUE_WIDTH-1:0] value,
                               input logic [RADIX_W-1:0] radix_raw,
                               input logic sgn);
    logic [RADIX_W-1:0] base;
    char_beat_t         beat;
    int                 k;
    base = radix_raw;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;

    minus_due  = sgn && (base == RADIX_SIGNED) && value[VALUE_WIDTH-1];
    quotient_r = minus_due ? ({VALUE_WIDTH{1'b0}} - value) : value;
    n_digits   = 0;
    if (quotient_r == '0) begin
      digit_mem[0] = '0;
      n_digits     = 1;
    end
    while (quotient_r != '0 && n_digits < DIGIT_DEPTH) begin
      digit_mem[n_digits] = DIGIT_W'(quotient_r % VALUE_WIDTH'(base));
      quotient_r          = quotient_r / VALUE_WIDTH'(base);
      n_digits++;
    end

    if (minus_due) begin
      beat.character = CHAR_MINUS;
      beat.last      = 1'b0;
      owed_chars.push_back(beat);
      minus_due = 1'b0;
    end
    for (k = n_digits - 1; k >= 0; k--) begin
      beat.character = ascii_of_digit(digit_mem[k]);
      beat.last      = (k == 0);
      owed_chars.push_back(beat);
    end
  endtask

  // Check the output beat first: it can never belong to a number taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fails = 0;
      owed_chars.delete();
      owed_chars_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_chars.size() == 0) begin
          $display("%0t: unexpected character beat: got char %h last %b",
                   $time, out_char_i, out_last_i);
          fails++;
        end else begin
          want = owed_chars.pop_front();
          if (out_char_i !== want.character) begin
            $display("%0t: character mismatch: expected %h got %h",
                     $time, want.character, out_char_i);
            fails++;
          end
          if (out_last_i !== want.last) begin
            $display("%0t: last mismatch: expected %b got %b",
                     $time, want.last, out_last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expand_number(in_value_i, in_radix_i, in_signed_i);
      end
      owed_chars_o <= owed_chars.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ bench/integer_to_ascii_digits_top_tb.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_top_tb
// Drives numbers into the digit converter, directed corner cases first and
// then random ones, with random gaps on the sender and random stalls on the
// receiver; the checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itoa_pkg::*;

  localparam int VW            = 32;
  localparam int RANDOM_ITEMS  = 128;
  localparam int CALM_ITEMS    = 30;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 2000;

  logic clk_i;
  logic rst_ni;
  logic gaps_on;
  int   owed_chars;
  int   fail_count;
  int   quiet_cycles;

  itoa_in_if #(.VALUE_WIDTH(VW)) in_if ();
  itoa_out_if                    out_if ();

  integer_to_ascii_digits_top #(
    .VALUE_WIDTH(VW),
    .DIGIT_DEPTH(32)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  integer_to_ascii_digits_checker #(
    .VALUE_WIDTH(VW),
    .DIGIT_DEPTH(32)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_value_i  (in_if.value),
    .in_radix_i  (in_if.radix),
    .in_signed_i (in_if.signed_mode),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_char_i  (out_if.character),
    .out_last_i  (out_if.last),
    .owed_chars_o(owed_chars),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the receiver in random bursts while gaps are enabled
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // End the run when neither channel has moved a beat for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one number and hold it until the block takes it
  task automatic send_number(input logic [VW-1:0] value, input logic [RADIX_W-1:0] base,
                             input logic sgn);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.value       <= value;
    in_if.radix       <= base;
    in_if.signed_mode <= sgn;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Hold the sender off until every owed character has left
  task automatic drain_chars();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (owed_chars != 0) @(posedge clk_i);
  endtask

  function automatic logic [VW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return VW'($urandom_range(0, 40));
      1: return 32'h8000_0000 + VW'($urandom_range(0, 3));
      2: return 32'hFFFF_FFFF - VW'($urandom_range(0, 3));
      3: return (VW'(1) << $urandom_range(0, VW - 1)) - VW'($urandom_range(0, 1));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int i;
    rst_ni            = 1'b0;
    gaps_on           = 1'b1;
    in_if.valid       = 1'b0;
    in_if.value       = '0;
    in_if.radix       = RADIX_SIGNED;
    in_if.signed_mode = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero, field extremes, sign handling and radix saturation
    send_number(32'h0000_0000, RADIX_SIGNED, 1'b0);
    send_number(32'h0000_0000, RADIX_SIGNED, 1'b1);
    send_number(32'hFFFF_FFFF, RADIX_MIN,    1'b0);
    send_number(32'hFFFF_FFFF, RADIX_MIN,    1'b1);
    send_number(32'hFFFF_FFFF, RADIX_MAX,    1'b0);
    send_number(32'hFFFF_FFFF, RADIX_SIGNED, 1'b0);
    send_number(32'hFFFF_FFFF, RADIX_SIGNED, 1'b1);
    send_number(32'h8000_0000, RADIX_SIGNED, 1'b1);
    send_number(32'h8000_0000, RADIX_MAX,    1'b1);
    send_number(32'h7FFF_FFFF, RADIX_SIGNED, 1'b1);
    send_number(32'hABCD_EF01, RADIX_MAX,    1'b0);
    send_number(32'h0000_0001, RADIX_SIGNED, 1'b1);
    send_number(32'h0000_0005, 5'd0,         1'b0);
    send_number(32'h0000_0005, 5'd1,         1'b1);
    send_number(32'h0000_00FF, 5'd17,        1'b0);
    send_number(32'hFEDC_BA98, 5'd31,        1'b1);
    send_number(32'h1234_5678, 5'd3,         1'b0);
    send_number(32'h1234_5678, 5'd7,         1'b1);
    send_number(32'h1234_5678, 5'd8,         1'b0);
    send_number(32'hDEAD_BEEF, 5'd11,        1'b1);
    send_number(32'hDEAD_BEEF, 5'd15,        1'b0);
    send_number(32'h0000_000F, 5'd16,        1'b0);
    drain_chars();

    // Random numbers, quiet handshakes for the last stretch
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_chars();
      if (i == RANDOM_ITEMS - CALM_ITEMS) gaps_on = 1'b0;
      send_number(pick_value(),
                  ($urandom_range(0, 4) == 0) ? RADIX_W'($urandom_range(0, 31))
                                              : RADIX_W'($urandom_range(2, 16)),
                  1'($urandom_range(0, 1)));
    end
    drain_chars();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && owed_chars == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ integer_to_ascii_digits_top.f @@
src/itoa_pkg.sv
src/itoa_in_if.sv
src/itoa_out_if.sv
src/itoa_dp.sv
src/itoa_ctrl.sv
src/integer_to_ascii_digits_top.sv
bench/integer_to_ascii_digits_checker.sv
bench/integer_to_ascii_digits_top_tb.sv
